// ----- rtl/bfba_pkg.sv -----
// ----------------------------------------------------------------------------
// bfba_pkg
// Shared constants and types for the best-fit block allocator.
// ----------------------------------------------------------------------------
package bfba_pkg;

    // Table geometry
    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_BITS   = $clog2(NUM_BLOCKS);
    localparam int CNT_BITS   = $clog2(NUM_BLOCKS + 1);

    // Configuration register
    localparam int               BIU_BITS  = 5;
    localparam logic [BIU_BITS-1:0] BIU_RESET = BIU_BITS'(16);

    // Word field widths
    localparam int TAG_BITS = 8;
    localparam int REQ_BITS = 16;

    // Word modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_ALLOC = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

endpackage

// ----- rtl/best_fit_block_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// best_fit_block_allocator_unit
// Best-fit allocator over a table of block free sizes held in a
// synchronous memory, scanned one entry per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (s_valid/s_ready) are either loads (s_mode = 0), which
//   write one block's free size, or allocate requests (s_mode = 1).
//   A load writes the free size directly and produces no output word.
//   An allocate request scans the first blocks_in_use entries of the
//   table, one memory read per cycle, then writes back the reduced free
//   size of the best-fitting block and posts one output word
//   (m_valid/m_ready). The scan reads count entries, count being
//   blocks_in_use capped at the table size, through the single memory
//   read port. The next word is accepted once the result sits in the
//   output register, so a load can proceed while an earlier result
//   waits. When the receiver stalls, a finished allocate holds in its
//   last state until the output register frees up. Reset clears every
//   entry to zero through per-entry valid bits (no clearing pass), sets
//   blocks_in_use to 16 and empties the output register. cfg_write_en
//   writes blocks_in_use; the user must write it only while idle, as the
//   block itself does not enforce this.
// ----------------------------------------------------------------------------
module best_fit_block_allocator_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_write_en,
    input  logic [bfba_pkg::BIU_BITS-1:0]     cfg_write_data,
    // input words
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_mode,
    input  logic [bfba_pkg::IDX_BITS-1:0]     s_block_index,
    input  logic [bfba_pkg::REQ_BITS-1:0]     s_size_value,
    input  logic [bfba_pkg::TAG_BITS-1:0]     s_request_tag,
    input  logic                              s_last_request,
    // output words
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_allocated,
    output logic [bfba_pkg::IDX_BITS-1:0]     m_chosen_block,
    output logic [bfba_pkg::SIZE_BITS-1:0]    m_space_left,
    output logic [bfba_pkg::TAG_BITS-1:0]     m_tag_out,
    output logic                              m_last_result
);

    localparam int NB = bfba_pkg::NUM_BLOCKS;
    localparam int IW = bfba_pkg::IDX_BITS;
    localparam int CW = bfba_pkg::CNT_BITS;
    localparam int SW = bfba_pkg::SIZE_BITS;
    localparam int TW = bfba_pkg::TAG_BITS;
    localparam int BW = bfba_pkg::BIU_BITS;

    // Free-size memory, registered read
    logic [SW-1:0] mem [NB];
    logic [SW-1:0] rdata_reg;
    logic          rd_vld_reg;
    logic [NB-1:0] vld_reg, vld_next;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [SW-1:0] mem_wdata;
    logic          mem_re;
    logic [IW-1:0] mem_raddr;

    // Control and request registers
    bfba_pkg::state_t state_reg, state_next;
    logic [BW-1:0] biu_reg, biu_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] issue_reg, issue_next;
    logic          cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0] cmp_idx_reg, cmp_idx_next;
    logic          found_reg, found_next;
    logic [IW-1:0] best_idx_reg, best_idx_next;
    logic [SW-1:0] best_val_reg, best_val_next;
    logic [SW-1:0] size_reg, size_next;
    logic [TW-1:0] tag_reg, tag_next;
    logic          last_reg, last_next;

    // Output register
    logic          m_valid_reg, m_valid_next;
    logic          alloc_reg, alloc_next;
    logic [IW-1:0] chosen_reg, chosen_next;
    logic [SW-1:0] left_reg, left_next;
    logic [TW-1:0] tag_out_reg, tag_out_next;
    logic          last_out_reg, last_out_next;

    logic [SW-1:0] entry;
    logic [SW-1:0] remain;
    logic          s_fire;
    logic          out_free;

    // Memory array and registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg  <= mem[mem_raddr];
            rd_vld_reg <= vld_reg[mem_raddr];
        end
    end

    // Never-written entries read as zero
    assign entry  = rd_vld_reg ? rdata_reg : '0;
    assign remain = best_val_reg - size_reg;

    assign s_ready  = (state_reg == bfba_pkg::ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Next state and datapath control
    always_comb begin
        state_next    = state_reg;
        biu_next      = biu_reg;
        count_next    = count_reg;
        issue_next    = issue_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        size_next     = size_reg;
        tag_next      = tag_reg;
        last_next     = last_reg;
        vld_next      = vld_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        alloc_next    = alloc_reg;
        chosen_next   = chosen_reg;
        left_next     = left_reg;
        tag_out_next  = tag_out_reg;
        last_out_next = last_out_reg;
        mem_we        = 1'b0;
        mem_waddr     = best_idx_reg;
        mem_wdata     = remain;
        mem_re        = 1'b0;
        mem_raddr     = issue_reg[IW-1:0];

        if (cfg_write_en) begin
            biu_next = cfg_write_data;
        end

        unique case (state_reg)
            bfba_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (s_mode == bfba_pkg::MODE_LOAD) begin
                        // load: store the free size directly
                        mem_we               = 1'b1;
                        mem_waddr            = s_block_index;
                        mem_wdata            = SW'(s_size_value);
                        vld_next[s_block_index] = 1'b1;
                    end else begin
                        // allocate: latch request, clamp search count
                        if (32'(biu_reg) > 32'(NB)) begin
                            count_next = CW'(NB);
                        end else begin
                            count_next = CW'(biu_reg);
                        end
                        size_next   = SW'(s_size_value);
                        tag_next    = s_request_tag;
                        last_next   = s_last_request;
                        issue_next  = '0;
                        found_next  = 1'b0;
                        state_next  = bfba_pkg::ST_SCAN;
                    end
                end
            end

            bfba_pkg::ST_SCAN: begin
                // issue one read per cycle
                if (issue_reg < count_reg) begin
                    mem_re       = 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = issue_reg[IW-1:0];
                    issue_next   = issue_reg + CW'(1);
                end
                // compare the entry read last cycle
                if (cmp_vld_reg) begin
                    if (entry >= size_reg && (!found_reg || entry < best_val_reg)) begin
                        found_next    = 1'b1;
                        best_idx_next = cmp_idx_reg;
                        best_val_next = entry;
                    end
                end
                if (issue_reg == count_reg && !cmp_vld_reg) begin
                    state_next = bfba_pkg::ST_EMIT;
                end
            end

            bfba_pkg::ST_EMIT: begin
                // write back and post the result once the slot is free
                if (out_free) begin
                    mem_we        = found_reg;
                    if (found_reg) begin
                        vld_next[best_idx_reg] = 1'b1;
                    end
                    m_valid_next  = 1'b1;
                    alloc_next    = found_reg;
                    chosen_next   = found_reg ? best_idx_reg : '0;
                    left_next     = found_reg ? remain : '0;
                    tag_out_next  = tag_reg;
                    last_out_next = last_reg;
                    state_next    = bfba_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = bfba_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bfba_pkg::ST_IDLE;
            biu_reg     <= bfba_pkg::BIU_RESET;
            vld_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            biu_reg     <= biu_next;
            vld_reg     <= vld_next;
            cmp_vld_reg <= cmp_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        count_reg    <= count_next;
        issue_reg    <= issue_next;
        cmp_idx_reg  <= cmp_idx_next;
        found_reg    <= found_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        size_reg     <= size_next;
        tag_reg      <= tag_next;
        last_reg     <= last_next;
        alloc_reg    <= alloc_next;
        chosen_reg   <= chosen_next;
        left_reg     <= left_next;
        tag_out_reg  <= tag_out_next;
        last_out_reg <= last_out_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_allocated    = alloc_reg;
    assign m_chosen_block = chosen_reg;
    assign m_space_left   = left_reg;
    assign m_tag_out      = tag_out_reg;
    assign m_last_result  = last_out_reg;

endmodule

// ----- dv/best_fit_block_allocator_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_block_allocator_unit_test
// Self-checking bench for the best-fit block allocator. Load and allocate
// words go in over a valid/ready channel. A local best-fit table predicts
// each allocate result, and every output word is compared against the
// oldest prediction. Directed checks cover table extremes, ties, zero-size
// requests, failed fits and the search-count register, including zero and
// saturation. These are followed by random traffic with random gaps on
// both channels, a long receiver hold-off, and a final stretch with no
// idling.
// ----------------------------------------------------------------------------
module best_fit_block_allocator_unit_test;

    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 24;    // outlasts the longest allocate
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    localparam int NB = bfba_pkg::NUM_BLOCKS;
    localparam int IW = bfba_pkg::IDX_BITS;
    localparam int SW = bfba_pkg::SIZE_BITS;
    localparam int RW = bfba_pkg::REQ_BITS;
    localparam int TW = bfba_pkg::TAG_BITS;
    localparam int BW = bfba_pkg::BIU_BITS;

    typedef struct packed {
        logic          allocated;
        logic [IW-1:0] chosen_block;
        logic [SW-1:0] space_left;
        logic [TW-1:0] tag;
        logic          last_req;
    } alloc_result_t;

    logic          aclk;
    logic          aresetn;
    logic          cfg_write_en;
    logic [BW-1:0] cfg_write_data;
    logic          s_valid;
    logic          s_ready;
    logic          s_mode;
    logic [IW-1:0] s_block_index;
    logic [RW-1:0] s_size_value;
    logic [TW-1:0] s_request_tag;
    logic          s_last_request;
    logic          m_valid;
    logic          m_ready;
    logic          m_allocated;
    logic [IW-1:0] m_chosen_block;
    logic [SW-1:0] m_space_left;
    logic [TW-1:0] m_tag_out;
    logic          m_last_result;

    // Local copy of the allocator state
    logic [SW-1:0] free_size_tbl [NB];
    logic [BW-1:0] search_count;
    alloc_result_t expected_allocs [$];

    int mismatch_count = 0;
    int idle_cycles    = 0;
    bit calm           = 1'b0;   // no idling on either side
    bit hold_req       = 1'b0;   // ask the receiver for a long hold-off

    best_fit_block_allocator_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_block_index  (s_block_index),
        .s_size_value   (s_size_value),
        .s_request_tag  (s_request_tag),
        .s_last_request (s_last_request),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_allocated    (m_allocated),
        .m_chosen_block (m_chosen_block),
        .m_space_left   (m_space_left),
        .m_tag_out      (m_tag_out),
        .m_last_result  (m_last_result)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Best fit over the active entries; ties keep the lowest index
    function automatic alloc_result_t best_fit_predict(input logic [RW-1:0] req,
                                                       input logic [TW-1:0] tag,
                                                       input logic last_req);
        alloc_result_t r;
        int span;
        int best;
        best = -1;
        span = (int'(search_count) > NB) ? NB : int'(search_count);
        for (int j = 0; j < span; j++) begin
            if (free_size_tbl[j] >= req &&
                (best < 0 || free_size_tbl[j] < free_size_tbl[best])) begin
                best = j;
            end
        end
        r.allocated    = (best >= 0);
        r.chosen_block = '0;
        r.space_left   = '0;
        if (best >= 0) begin
            free_size_tbl[best] = free_size_tbl[best] - req;
            r.chosen_block      = IW'(best);
            r.space_left        = free_size_tbl[best];
        end
        r.tag      = tag;
        r.last_req = last_req;
        return r;
    endfunction

    // Send one word; called and returns at a falling edge
    task automatic send_word(input logic mode, input logic [IW-1:0] idx,
                             input logic [RW-1:0] size,
                             input logic [TW-1:0] tag, input logic last_req);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_mode         = mode;
        s_block_index  = idx;
        s_size_value   = size;
        s_request_tag  = tag;
        s_last_request = last_req;
        s_valid        = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (mode == bfba_pkg::MODE_LOAD) begin
            free_size_tbl[idx] = size;
        end else begin
            expected_allocs.push_back(best_fit_predict(size, tag, last_req));
        end
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic send_load(input logic [IW-1:0] idx, input logic [RW-1:0] size);
        send_word(bfba_pkg::MODE_LOAD, idx, size, TW'($urandom), 1'($urandom));
    endtask

    task automatic send_alloc(input logic [RW-1:0] size, input logic [TW-1:0] tag,
                              input logic last_req);
        send_word(bfba_pkg::MODE_ALLOC, IW'($urandom), size, tag, last_req);
    endtask

    task automatic wait_for_results;
        while (expected_allocs.size() != 0) @(negedge aclk);
    endtask

    // Register write only once the block has gone quiet
    task automatic write_search_count(input logic [BW-1:0] value);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_write_data = value;
        cfg_write_en   = 1'b1;
        @(negedge aclk);
        cfg_write_en   = 1'b0;
        search_count   = value;
    endtask

    // Mostly requests aimed at current entries: exact fits, partial, misses
    task automatic send_random_word;
        logic [RW-1:0] entry;
        logic [RW-1:0] size;
        entry = free_size_tbl[$urandom_range(0, NB - 1)];
        if ($urandom_range(0, 99) < 35) begin
            case ($urandom_range(0, 3))
                0: size = RW'($urandom);
                1: size = '1;
                default: size = RW'($urandom_range(0, 4095));
            endcase
            send_load(IW'($urandom), size);
        end else begin
            case ($urandom_range(0, 5))
                0: size = entry;
                1: size = entry >> 1;
                2: size = RW'($urandom_range(0, 63));
                3: size = RW'($urandom);
                4: size = '0;
                default: size = entry + 1'b1;
            endcase
            send_alloc(size, TW'($urandom), 1'($urandom));
        end
    endtask

    // Empty table at reset; the default count must reach the top entry
    task automatic test_after_reset;
        send_alloc(16'h0000, 8'h00, 1'b0);
        send_alloc(16'hFFFF, 8'hFF, 1'b1);
        send_load(4'd15, 16'd5);
        send_alloc(16'd5, 8'h01, 1'b0);
        write_search_count(5'd16);
    endtask

    // Extremes, ties, zero request, failed fit
    task automatic test_best_fit;
        send_load(4'd15, 16'hFFFF);
        send_load(4'd0, 16'h0000);
        send_load(4'd3, 16'd100);
        send_load(4'd7, 16'd100);
        send_load(4'd9, 16'd40);
        send_alloc(16'hFFFF, 8'h10, 1'b0);
        send_alloc(16'd50, 8'h11, 1'b0);
        send_alloc(16'd50, 8'h12, 1'b0);
        send_alloc(16'd0, 8'h13, 1'b0);
        send_alloc(16'd41, 8'h14, 1'b0);
        send_alloc(16'd200, 8'hAA, 1'b1);
        send_load(4'd15, 16'hAAAA);
        send_load(4'd12, 16'h5555);
        send_alloc(16'h5555, 8'h55, 1'b0);
        send_alloc(16'd1, 8'hFE, 1'b1);
        send_alloc(16'hAAAA, 8'h7F, 1'b0);
    endtask

    // Zero count, a single entry, saturation above the table size
    task automatic test_search_count;
        write_search_count(5'd0);
        send_alloc(16'd0, 8'h20, 1'b0);
        write_search_count(5'd1);
        send_load(4'd0, 16'd10);
        send_load(4'd1, 16'd1000);
        send_alloc(16'd5, 8'h21, 1'b0);
        send_alloc(16'd6, 8'h22, 1'b1);
        write_search_count(5'd31);
        send_load(4'd15, 16'd7);
        send_alloc(16'd7, 8'h23, 1'b0);
        send_alloc(16'd1000, 8'h24, 1'b0);
        write_search_count(5'd17);
        send_load(4'd14, 16'd3);
        send_alloc(16'd2, 8'h25, 1'b1);
    endtask

    // Random phases over several search counts
    task automatic test_random_traffic;
        logic [BW-1:0] counts [6];
        counts = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd17, 5'd16};
        counts[3] = BW'($urandom_range(2, 15));
        foreach (counts[p]) begin
            write_search_count(counts[p]);
            repeat (65) send_random_word();
        end
    endtask

    // Receiver holds off while words keep coming, so the input stalls
    task automatic test_backpressure;
        for (int k = 0; k < 4; k++) send_load(IW'(k), 16'd500);
        hold_req = 1'b1;
        for (int k = 0; k < 16; k++) begin
            send_alloc(RW'($urandom_range(1, 40)), TW'(k), 1'(k == 15));
        end
    endtask

    task automatic test_calm_tail;
        wait_for_results();
        calm = 1'b1;
        repeat (60) send_random_word();
    endtask

    // Stimulus and final verdict
    initial begin
        aresetn        = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        s_valid        = 1'b0;
        s_mode         = bfba_pkg::MODE_LOAD;
        s_block_index  = '0;
        s_size_value   = '0;
        s_request_tag  = '0;
        s_last_request = 1'b0;
        foreach (free_size_tbl[j]) free_size_tbl[j] = '0;
        search_count   = bfba_pkg::BIU_RESET;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        test_after_reset();
        test_best_fit();
        test_search_count();
        test_random_traffic();
        test_backpressure();
        test_calm_tail();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_allocs.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Receiver: random stall bursts, one long hold on request
    initial begin
        m_ready = 1'b0;
        forever begin
            if (hold_req) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
                @(negedge aclk);
            end
        end
    end

    // Compare each output word with the oldest prediction
    always @(posedge aclk) begin
        alloc_result_t got;
        alloc_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_allocated, m_chosen_block, m_space_left, m_tag_out, m_last_result};
            if (expected_allocs.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("ERROR: unexpected word alloc=%0b blk=%0d left=%0d tag=%0d last=%0b",
                             got.allocated, got.chosen_block, got.space_left, got.tag,
                             got.last_req);
                end
            end else begin
                want = expected_allocs.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("ERROR: exp alloc=%0b blk=%0d left=%0d tag=%0d last=%0b",
                                 want.allocated, want.chosen_block, want.space_left,
                                 want.tag, want.last_req);
                        $display("       got alloc=%0b blk=%0d left=%0d tag=%0d last=%0b",
                                 got.allocated, got.chosen_block, got.space_left,
                                 got.tag, got.last_req);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any word moving
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule
